FILE: rtl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int DEPTH   = 16;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    FUNC_INSERT     = 3'd0,
    FUNC_POP_FIRST  = 3'd1,
    FUNC_POP_LAST   = 3'd2,
    FUNC_PEEK       = 3'd3,
    FUNC_CLEAR      = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [7:0]         prio;
  } entry_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    logic   ins_en;
    logic   rem_en;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       occ,
  input  wire logic       left_b,
  input  wire entry_t     left_entry,
  input  wire entry_t     right_entry,
  output logic            b,
  output entry_t          entry
);

  // b: this slot is at or behind the insert position (ties stay ahead)
  assign b = !occ || (entry.prio > ctrl.new_entry.prio);

  always_ff @(posedge clk) begin
    if (ctrl.ins_en && b) begin
      entry <= left_b ? left_entry : ctrl.new_entry;
    end else if (ctrl.rem_en) begin
      entry <= right_entry;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sorted_priority_queue_unit.sv
// Channel   Signals                                      Handshake
// command   func, value_in, priority_in                  start && !busy
// result    value_out, priority_out, status, occupancy   done (one cycle)
//
// One command per cycle; its result strobes on done the following cycle.
// busy never rises: the shift chain of cells inserts or shifts all entries
// at once, so no operation holds off the next command.
// Synchronous reset empties the queue and clears done; slot contents are
// left as they are. The result side cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_unit
  import spq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         func,
  input  wire logic signed [31:0] value_in,
  input  wire logic [7:0]         priority_in,
  output logic                    done,
  output logic signed [31:0]      value_out,
  output logic [7:0]              priority_out,
  output logic [1:0]              status,
  output logic [4:0]              occupancy
);

  logic               accept;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  cell_ctrl_t         ctrl;
  entry_t             cell_q [DEPTH];
  logic               cell_b [DEPTH];
  logic               cell_occ [DEPTH];
  logic               last_sel [DEPTH];
  entry_t             last_entry;
  entry_t             res_entry;
  status_t            res_status;
  logic               full;
  logic               empty;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == COUNT_W'(DEPTH));
  assign empty  = (count == '0);

  assign ctrl.ins_en          = accept && (func == FUNC_INSERT) && !full;
  assign ctrl.rem_en          = accept && (func == FUNC_POP_FIRST) && !empty;
  assign ctrl.new_entry.value = value_in;
  assign ctrl.new_entry.prio  = priority_in;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_occ[i] = (COUNT_W'(i) < count);
    assign last_sel[i] = (COUNT_W'(i + 1) == count);

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (cell_occ[i]),
      .left_b      ((i == 0) ? 1'b0 : cell_b[(i == 0) ? 0 : i - 1]),
      .left_entry  (cell_q[(i == 0) ? 0 : i - 1]),
      .right_entry (cell_q[(i == DEPTH - 1) ? DEPTH - 1 : i + 1]),
      .b           (cell_b[i]),
      .entry       (cell_q[i])
    );
  end

  // AND-OR select of the tail slot
  always_comb begin
    last_entry = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (last_sel[i]) begin
        last_entry = last_entry | cell_q[i];
      end
    end
  end

  always_comb begin
    count_next = count;
    res_entry  = '0;
    res_status = ST_OK;
    unique case (func)
      FUNC_INSERT: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          res_entry  = ctrl.new_entry;
          count_next = count + COUNT_W'(1);
        end
      end
      FUNC_POP_FIRST: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_entry  = cell_q[0];
          count_next = count - COUNT_W'(1);
        end
      end
      FUNC_POP_LAST: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_entry  = last_entry;
          count_next = count - COUNT_W'(1);
        end
      end
      FUNC_PEEK: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_entry = cell_q[0];
        end
      end
      FUNC_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_out    <= res_entry.value;
      priority_out <= res_entry.prio;
      status       <= res_status;
      occupancy    <= 5'(count_next);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/spq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_checker
  import spq_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [1:0] status,
  input wire logic [4:0] occupancy
);

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("no result after a command transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without a command transfer");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (occupancy == 5'(DEPTH)))
    else $error("full status with queue not full");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (occupancy == 5'd0))
    else $error("empty status with entries held");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (occupancy <= 5'(DEPTH)))
    else $error("occupancy above depth");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .status    (status),
  .occupancy (occupancy)
);

`default_nettype wire
